// File: rtl/log9_pkg.sv
// Shared constants, kernel table, helper functions and result type for the LoG edge-sign filter.
package log9_pkg;

	localparam int MAX_WIDTH_DEF      = 512;
	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int KERNEL_SIZE        = 9;
	localparam int HALF_K             = 5;
	localparam int STORE_LINES        = 8;
	localparam int ROW_LIMIT          = 512;
	localparam int PIX_W              = 8;
	localparam int CFG_W              = 10;
	localparam int GSUM_W             = 10;
	localparam int OUTQ_DEPTH         = 16;
	localparam longint MICRO          = 1000000;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [1:0] SIGN_NEG  = 2'b11;
	localparam logic [1:0] SIGN_ZERO = 2'b00;
	localparam logic [1:0] SIGN_POS  = 2'b01;

	// One quadrant of the kernel in millionths; the kernel mirrors in both axes.
	localparam int QUAD_MICRO [HALF_K][HALF_K] = '{
		'{  81641,  365518,  998325,   1745668,   2080704},
		'{ 365518, 1456020, 3361998,   4839310,   5218347},
		'{ 998325, 3361998, 5409023,   3077873,    294243},
		'{1745668, 4839310, 3077873, -11762411, -23086993},
		'{2080704, 5218347,  294243, -23086993, -40000000}};

	typedef struct packed {
		logic [1:0] edge_sign;
		logic [8:0] out_row;
		logic [8:0] out_col;
		logic       frame_last;
	} res_t;

	function automatic int fold(input int k);
		return (k < HALF_K) ? k : (KERNEL_SIZE - 1 - k);
	endfunction

	// Coefficient in fixed point, rounded to nearest with halves away from zero.
	function automatic longint coef_scale(input int m, input int frac);
		longint mag;
		longint q;
		mag = (m < 0) ? -longint'(m) : longint'(m);
		q = ((mag << frac) + MICRO / 2) / MICRO;
		return (m < 0) ? -q : q;
	endfunction

endpackage

// File: rtl/log9_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module log9_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/log9_outq.sv
// Small result queue that parts the filter pipeline from the output channel.
module log9_outq
	import log9_pkg::*;
#(
	parameter int DEPTH = OUTQ_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	input  logic pop,
	output logic out_valid,
	output res_t out_data
);

	localparam int PTR_W = $clog2(DEPTH);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/log_9x9_convolution_sign.sv
// Top level of the 9x9 Laplacian-of-Gaussian edge-sign filter on a raster pixel stream.
//
// Pixels enter on the input channel (pixel, frame_start, in_valid, in_stall) in raster
// order, one item per clock when the output side keeps up. frame_start on an item puts
// it at row 0, column 0; without it the position counters wrap at the end of each frame.
// For every pixel whose 9x9 window lies wholly inside the frame, one item leaves on the
// output channel (edge_sign, out_row, out_col, frame_last, out_valid, out_stall): the
// sign of the exact kernel sum, the window's top-left position and an end-of-frame flag.
// Sustained throughput is one pixel per clock while the output side keeps up; it is
// set by the line store, one RAM word per column holding all eight previous rows, read
// and written back once per pixel. The result queue holds sixteen items. A credit
// counter reserves a queue slot for each accepted pixel that will give a result, so
// when the receiver holds out_stall the block keeps taking pixels until all slots are
// spoken for, then raises in_stall. Reset clears the counters, the window and the
// queue and sets both sizes to 400; the line store is left as it is and is never read
// before it has been written for a window that gives a result. Sizes must be written
// on the cfg port while the block is idle; the block itself does not enforce this.
module log_9x9_convolution_sign
	import log9_pkg::*;
#(
	parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [PIX_W-1:0]   pixel,
	input  logic               frame_start,
	input  logic               in_valid,
	output logic               in_stall,
	output logic signed [1:0]  edge_sign,
	output logic [8:0]         out_row,
	output logic [8:0]         out_col,
	output logic               frame_last,
	output logic               out_valid,
	input  logic               out_stall,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int WW      = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int WORD_W  = STORE_LINES * PIX_W;
	localparam int COEF_W  = COEF_FRAC_BITS + 7;
	localparam int PROD_W  = COEF_W + GSUM_W + 1;
	localparam int RSUM_W  = PROD_W + 3;
	localparam int TOT_W   = PROD_W + 6;
	localparam int CRED_W  = $clog2(OUTQ_DEPTH + 1);

	// Configuration registers.
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(400);
			height_q <= CFG_W'(400);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default:          width_q  <= width_q;
			endcase
		end
	end

	// Sizes clamped to what the line store and the output fields can hold.
	logic [WW-1:0] w_eff;
	logic [9:0]    h_eff;

	always_comb begin
		if (width_q < CFG_W'(KERNEL_SIZE)) begin
			w_eff = WW'(KERNEL_SIZE);
		end else if (WW'(width_q) > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q < 10'(KERNEL_SIZE)) begin
			h_eff = 10'(KERNEL_SIZE);
		end else if (height_q > 10'(ROW_LIMIT)) begin
			h_eff = 10'(ROW_LIMIT);
		end else begin
			h_eff = height_q;
		end
	end

	// Position of the incoming pixel and of the one after it.
	logic [CW-1:0]   col_q;
	logic [8:0]      row_q;
	logic [CRED_W-1:0] credit_q;
	logic [WW-1:0]   c_cur;
	logic [9:0]      r_cur;
	logic [WW-1:0]   c_nxt;
	logic [9:0]      r_nxt;
	logic [WW-1:0]   c_off;
	logic            accept;
	logic            produce;
	logic            is_last;

	assign in_stall = (credit_q == CRED_W'(OUTQ_DEPTH));
	assign accept   = in_valid && !in_stall;

	always_comb begin
		c_cur = frame_start ? '0 : WW'(col_q);
		r_cur = frame_start ? '0 : {1'b0, row_q};
		if (c_cur >= w_eff) begin
			c_cur = '0;
			r_cur = r_cur + 10'd1;
		end
		if (r_cur >= h_eff) begin
			r_cur = '0;
		end
		c_nxt = c_cur + WW'(1);
		r_nxt = r_cur;
		if (c_nxt >= w_eff) begin
			c_nxt = '0;
			r_nxt = r_cur + 10'd1;
			if (r_nxt >= h_eff) begin
				r_nxt = '0;
			end
		end
		produce = (r_cur >= 10'(KERNEL_SIZE - 1)) && (c_cur >= WW'(KERNEL_SIZE - 1));
		is_last = (r_cur == h_eff - 10'd1) && (c_cur == w_eff - WW'(1));
		c_off   = c_cur - WW'(KERNEL_SIZE - 1);
	end

	// Stage 1: line store word read; forwarding covers a write to the same column
	// in the cycle of the read.
	logic            v_s1;
	logic            fwd_s1;
	logic [PIX_W-1:0] px_s1;
	logic [2:0]      slot_s1;
	logic [CW-1:0]   c_s1;
	logic            res_v_s1;
	res_t            res_s1;
	logic [WORD_W-1:0] rdata;
	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] wdata_q;
	logic [PIX_W-1:0] new_col [KERNEL_SIZE];
	logic [2:0]      slot_i;

	log9_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (v_s1),
		.waddr(c_s1),
		.wdata(wdata),
		.re   (accept),
		.raddr(c_cur[CW-1:0]),
		.rdata(rdata)
	);

	// The slot index wraps within the eight rows of a word.
	always_comb begin
		word  = fwd_s1 ? wdata_q : rdata;
		wdata = word;
		wdata[slot_s1 * PIX_W +: PIX_W] = px_s1;
		slot_i = slot_s1;
		for (int i = 0; i < STORE_LINES; i++) begin
			slot_i = slot_s1 + 3'(i);
			new_col[i] = word[slot_i * PIX_W +: PIX_W];
		end
		new_col[KERNEL_SIZE - 1] = px_s1;
	end

	// Stage 2: the window, shifted left with the new column on the right.
	logic [PIX_W-1:0] win_q [KERNEL_SIZE][KERNEL_SIZE];
	logic            res_v_s2;
	res_t            res_s2;

	// Stage 3: pixels that share a coefficient are added first.
	logic [GSUM_W-1:0] gsum;
	logic [GSUM_W-1:0] gsum_a [HALF_K][HALF_K];
	logic [GSUM_W-1:0] gsum_s3 [HALF_K][HALF_K];
	logic            res_v_s3;
	res_t            res_s3;

	always_comb begin
		for (int a = 0; a < HALF_K; a++) begin
			for (int b = 0; b < HALF_K; b++) begin
				gsum_a[a][b] = '0;
			end
		end
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			for (int j = 0; j < KERNEL_SIZE; j++) begin
				gsum = gsum_a[fold(i)][fold(j)] + GSUM_W'(win_q[i][j]);
				gsum_a[fold(i)][fold(j)] = gsum;
			end
		end
	end

	// Stage 4: one constant product per entry of the kernel quadrant.
	logic signed [PROD_W-1:0] prod_s4 [HALF_K][HALF_K];
	logic            res_v_s4;
	res_t            res_s4;

	// Stage 5: row sums; the total and its sign follow in front of the queue.
	logic signed [RSUM_W-1:0] rsum_s5 [HALF_K];
	logic            res_v_s5;
	res_t            res_s5;
	logic signed [RSUM_W-1:0] rsum_a [HALF_K];
	logic signed [TOT_W-1:0]  total;
	res_t            push_res;

	always_comb begin
		for (int a = 0; a < HALF_K; a++) begin
			rsum_a[a] = '0;
			for (int b = 0; b < HALF_K; b++) begin
				rsum_a[a] = rsum_a[a] + RSUM_W'(prod_s4[a][b]);
			end
		end
		total = '0;
		for (int a = 0; a < HALF_K; a++) begin
			total = total + TOT_W'(rsum_s5[a]);
		end
		push_res = res_s5;
		if (total < 0) begin
			push_res.edge_sign = SIGN_NEG;
		end else if (total == 0) begin
			push_res.edge_sign = SIGN_ZERO;
		end else begin
			push_res.edge_sign = SIGN_POS;
		end
	end

	// Control: counters, stage valids, credits and the window.
	logic pop;
	res_t out_res;

	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			credit_q <= '0;
			v_s1     <= 1'b0;
			fwd_s1   <= 1'b0;
			res_v_s1 <= 1'b0;
			res_v_s2 <= 1'b0;
			res_v_s3 <= 1'b0;
			res_v_s4 <= 1'b0;
			res_v_s5 <= 1'b0;
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				for (int j = 0; j < KERNEL_SIZE; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else begin
			if (accept) begin
				col_q <= c_nxt[CW-1:0];
				row_q <= r_nxt[8:0];
			end
			credit_q <= credit_q + CRED_W'(accept && produce) - CRED_W'(pop);
			v_s1     <= accept;
			fwd_s1   <= accept && v_s1 && (c_s1 == c_cur[CW-1:0]);
			res_v_s1 <= accept && produce;
			res_v_s2 <= res_v_s1;
			res_v_s3 <= res_v_s2;
			res_v_s4 <= res_v_s3;
			res_v_s5 <= res_v_s4;
			if (v_s1) begin
				for (int i = 0; i < KERNEL_SIZE; i++) begin
					for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
						win_q[i][j] <= win_q[i][j + 1];
					end
					win_q[i][KERNEL_SIZE - 1] <= new_col[i];
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1              <= pixel;
			slot_s1            <= r_cur[2:0];
			c_s1               <= c_cur[CW-1:0];
			res_s1.edge_sign   <= SIGN_ZERO;
			res_s1.out_row     <= r_cur[8:0] - 9'(KERNEL_SIZE - 1);
			res_s1.out_col     <= c_off[8:0];
			res_s1.frame_last  <= is_last;
		end
		if (v_s1) begin
			wdata_q <= wdata;
		end
		res_s2 <= res_s1;
		res_s3 <= res_s2;
		res_s4 <= res_s3;
		res_s5 <= res_s4;
		for (int a = 0; a < HALF_K; a++) begin
			for (int b = 0; b < HALF_K; b++) begin
				gsum_s3[a][b] <= gsum_a[a][b];
				prod_s4[a][b] <= $signed({1'b0, gsum_s3[a][b]})
					* COEF_W'(coef_scale(QUAD_MICRO[a][b], COEF_FRAC_BITS));
			end
			rsum_s5[a] <= rsum_a[a];
		end
	end

	log9_outq #(
		.DEPTH(OUTQ_DEPTH)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_v_s5),
		.push_data(push_res),
		.pop      (pop),
		.out_valid(out_valid),
		.out_data (out_res)
	);

	assign edge_sign  = out_res.edge_sign;
	assign out_row    = out_res.out_row;
	assign out_col    = out_res.out_col;
	assign frame_last = out_res.frame_last;

endmodule

// File: rtl/log9_checker.sv
// Port-level checks for the LoG edge-sign filter, bound to its top level.
module log9_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic signed [1:0] edge_sign,
	input logic [8:0]        out_row,
	input logic [8:0]        out_col,
	input logic              frame_last,
	input logic              out_valid,
	input logic              out_stall
);

	// A held result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(edge_sign) && $stable(out_row)
			&& $stable(out_col) && $stable(frame_last))
		else $error("result changed while stalled");

	// Only -1, 0 and +1 are ever given.
	a_sign_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> edge_sign != 2'sb10)
		else $error("invalid edge sign code");

	// The queue is empty in the first cycle after reset.
	a_reset_empty: assert property (@(posedge clk)
		arst_n && $past(!arst_n) |-> !out_valid)
		else $error("result present straight after reset");

	// With no input and a full reservation the block cannot free a slot by itself.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && out_stall |=> in_stall)
		else $error("input stall dropped without a result taken");

endmodule

bind log_9x9_convolution_sign log9_checker u_log9_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.edge_sign (edge_sign),
	.out_row   (out_row),
	.out_col   (out_col),
	.frame_last(frame_last),
	.out_valid (out_valid),
	.out_stall (out_stall)
);

// File: test/tb_log_9x9_convolution_sign.sv
// Self-checking testbench for the 9x9 LoG edge-sign filter: streams frames and checks every result.
module tb_log_9x9_convolution_sign
	import log9_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_MAX   = 512;
	localparam int CYCLE_CAP  = 1500000;
	localparam int RAND_ITEMS = 1750;
	localparam int DRAIN_WAIT = 12;

	typedef enum int {PAT_NOISE, PAT_BINARY, PAT_RAMP, PAT_FLAT, PAT_DISC} pattern_e;

	// Holds a private copy of the filter: sizes, line store, window and counters, plus
	// the queue of edge signs still owed by the block.
	class edge_scoreboard;
		longint        kern [9][9];
		bit [7:0]      lines [8*LINE_MAX];
		bit [7:0]      win [9][9];
		int            row_pos;
		int            col_pos;
		bit [9:0]      reg_width;
		bit [9:0]      reg_height;
		res_t          owed [$];
		int            errors;
		int            checked;

		function new();
			int quad [5][5] = '{
				'{  81641,  365518,  998325,   1745668,   2080704},
				'{ 365518, 1456020, 3361998,   4839310,   5218347},
				'{ 998325, 3361998, 5409023,   3077873,    294243},
				'{1745668, 4839310, 3077873, -11762411, -23086993},
				'{2080704, 5218347,  294243, -23086993, -40000000}};
			int qi;
			int qj;
			longint mag;
			longint q;
			for (int i = 0; i < 9; i++) begin
				for (int j = 0; j < 9; j++) begin
					qi = (i < 5) ? i : 8 - i;
					qj = (j < 5) ? j : 8 - j;
					mag = (quad[qi][qj] < 0) ? -longint'(quad[qi][qj]) : longint'(quad[qi][qj]);
					q = ((mag << 16) + 500000) / 1000000;
					kern[i][j] = (quad[qi][qj] < 0) ? -q : q;
					win[i][j] = '0;
				end
			end
			foreach (lines[k]) lines[k] = '0;
			row_pos = 0;
			col_pos = 0;
			reg_width = 10'd400;
			reg_height = 10'd400;
			errors = 0;
			checked = 0;
		endfunction

		function int eff_width();
			return (reg_width < 9) ? 9 : (reg_width > LINE_MAX) ? LINE_MAX : int'(reg_width);
		endfunction

		function int eff_height();
			return (reg_height < 9) ? 9 : (reg_height > 512) ? 512 : int'(reg_height);
		endfunction

		function void write_reg(logic idx, bit [9:0] value);
			if (idx == REG_IMAGE_WIDTH) reg_width = value;
			else reg_height = value;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Accepted pixel: move the window, update the line store and note any result.
		function void note_pixel(bit [7:0] px, bit fs);
			int w;
			int h;
			int r;
			int c;
			longint acc;
			res_t e;
			w = eff_width();
			h = eff_height();
			if (fs) begin
				row_pos = 0;
				col_pos = 0;
			end
			// A size shrunk under a running frame wraps the counters first.
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
			if (row_pos >= h) row_pos = 0;
			r = row_pos;
			c = col_pos;
			for (int i = 0; i < 9; i++)
				for (int j = 0; j < 8; j++) win[i][j] = win[i][j+1];
			for (int i = 0; i < 8; i++) win[i][8] = lines[((r + i) % 8) * LINE_MAX + c];
			win[8][8] = px;
			lines[(r % 8) * LINE_MAX + c] = px;
			if (r >= 8 && c >= 8) begin
				acc = 0;
				for (int i = 0; i < 9; i++)
					for (int j = 0; j < 9; j++) acc += kern[i][j] * longint'(win[i][j]);
				e.edge_sign = (acc < 0) ? SIGN_NEG : (acc > 0) ? SIGN_POS : SIGN_ZERO;
				e.out_row = 9'(r - 8);
				e.out_col = 9'(c - 8);
				e.frame_last = (r == h - 1) && (c == w - 1);
				owed.push_back(e);
			end
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= h) row_pos = 0;
			end
		endfunction

		function void check(logic [1:0] sg, logic [8:0] r, logic [8:0] c, logic fl);
			res_t e;
			if (owed.size() == 0) begin
				$error("unexpected item: edge_sign %0d out_row %0d out_col %0d", sg, r, c);
				errors++;
				return;
			end
			e = owed.pop_front();
			checked++;
			if (sg !== e.edge_sign) begin
				$error("edge_sign expected %0d actual %0d", e.edge_sign, sg);
				errors++;
			end
			if (r !== e.out_row) begin
				$error("out_row expected %0d actual %0d", e.out_row, r);
				errors++;
			end
			if (c !== e.out_col) begin
				$error("out_col expected %0d actual %0d", e.out_col, c);
				errors++;
			end
			if (fl !== e.frame_last) begin
				$error("frame_last expected %0d actual %0d", e.frame_last, fl);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic [7:0]        pixel;
	logic              frame_start;
	logic              in_valid;
	logic              in_stall;
	logic signed [1:0] edge_sign;
	logic [8:0]        out_row;
	logic [8:0]        out_col;
	logic              frame_last;
	logic              out_valid;
	logic              out_stall;
	logic              cfg_we;
	logic              cfg_index;
	logic [9:0]        cfg_data;

	edge_scoreboard sb;
	bit  steady;       // when set, neither side idles
	bit  open_frame;   // the last phase stopped part-way through a frame
	int  pixels_sent;
	int  phases;
	int  cycles;
	int  disc_row;
	int  disc_col;
	int  disc_rad;
	bit [7:0] flat_level;

	log_9x9_convolution_sign dut (
		.clk(clk), .arst_n(arst_n), .pixel(pixel), .frame_start(frame_start),
		.in_valid(in_valid), .in_stall(in_stall), .edge_sign(edge_sign),
		.out_row(out_row), .out_col(out_col), .frame_last(frame_last),
		.out_valid(out_valid), .out_stall(out_stall), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Cycle counter doubling as the watchdog for a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("log_9x9_convolution_sign verification failed");
			$finish;
		end
	end

	// The receiver holds off at random except during the steady stretch.
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 25);
	end

	// Every item leaving the block is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check(edge_sign, out_row, out_col, frame_last);
	end

	function automatic bit [7:0] pattern_pixel(pattern_e pat, int r, int c);
		int dr;
		int dc;
		case (pat)
			PAT_NOISE: begin
				return 8'($urandom_range(0, 255));
			end
			PAT_BINARY: begin
				return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			PAT_RAMP: begin
				return 8'(r * 9 + c * 13 + $urandom_range(0, 7));
			end
			PAT_FLAT: begin
				return flat_level;
			end
			default: begin
				dr = r - disc_row;
				dc = c - disc_col;
				return (dr * dr + dc * dc < disc_rad * disc_rad) ? 8'hFF : 8'h00;
			end
		endcase
	endfunction

	// Called just after a falling edge; returns just after the falling edge that follows
	// acceptance, so a back-to-back item keeps in_valid high without a second assignment.
	task automatic feed_pixel(bit [7:0] px, bit fs);
		while (!steady && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		pixel <= px;
		frame_start <= fs;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_pixel(px, fs);
		pixels_sent++;
		@(negedge clk);
	endtask

	// Sizes are only changed once every result is out and the pipeline has run dry.
	task automatic set_sizes(bit [9:0] wv, bit [9:0] hv);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= wv;
		@(negedge clk);
		sb.write_reg(REG_IMAGE_WIDTH, wv);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= hv;
		@(negedge clk);
		sb.write_reg(REG_IMAGE_HEIGHT, hv);
		cfg_we <= 1'b0;
		@(negedge clk);
		phases++;
	endtask

	// Streams whole frames of one pattern. Later frames may rely on the wrap instead of
	// frame_start, and now and then a frame is restarted part-way by a stray frame_start.
	// With a partial tail the phase stops inside a frame, after at least eight full rows,
	// so that the line store is fully written for a following shrink.
	task automatic run_frames(int nfr, pattern_e pat, bit fs_first, bit partial);
		int w;
		int h;
		int p;
		int stop;
		bit fs;
		w = sb.eff_width();
		h = sb.eff_height();
		for (int f = 0; f <= nfr; f++) begin
			if (f == nfr && !partial) break;
			stop = (f == nfr) ? $urandom_range(8 * w, w * h - 1) : w * h;
			disc_row = $urandom_range(0, h - 1);
			disc_col = $urandom_range(0, w - 1);
			disc_rad = $urandom_range(2, 8);
			p = 0;
			while (p < stop) begin
				fs = (p == 0) ? ((f == 0) ? fs_first : bit'($urandom_range(0, 1))) : 1'b0;
				if (p > 0 && f < nfr && $urandom_range(0, 599) == 0) begin
					fs = 1'b1;
					p = 0;
				end
				feed_pixel(pattern_pixel(pat, p / w, p % w), fs);
				p++;
			end
		end
		open_frame = partial;
	endtask

	initial begin
		bit [9:0]  nw;
		bit [9:0]  nh;
		int        ew;
		int        eh;
		bit        shrink;
		bit        fs_first;
		pattern_e  pat;
		sb = new();
		arst_n = 1'b0;
		pixel = '0;
		frame_start = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		steady = 1'b0;
		open_frame = 1'b0;
		pixels_sent = 0;
		phases = 0;
		cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: smallest frame with an all-black window (zero sum), an all-white one,
		// hard binary edges and a ramp.
		set_sizes(10'd9, 10'd9);
		flat_level = 8'h00;
		run_frames(1, PAT_FLAT, 1'b1, 1'b0);
		flat_level = 8'hFF;
		run_frames(1, PAT_FLAT, 1'b1, 1'b0);
		run_frames(1, PAT_BINARY, 1'b0, 1'b0);
		run_frames(1, PAT_RAMP, 1'b1, 1'b0);

		// Register extremes: over-range sizes for a short stretch of the first row, which
		// gives no result, then under-range sizes that clamp to the smallest frame.
		set_sizes(10'd1023, 10'd1023);
		for (int k = 0; k < 40; k++) feed_pixel(8'($urandom_range(0, 255)), k == 0);
		set_sizes(10'd0, 10'd0);
		run_frames(1, PAT_DISC, 1'b1, 1'b0);

		// Random phases of small frames.
		while (pixels_sent < RAND_ITEMS) begin
			steady = (pixels_sent > 600 && pixels_sent < 1000);
			nw = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 8)) : 10'($urandom_range(9, 20));
			nh = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 8)) : 10'($urandom_range(9, 14));
			ew = (nw < 9) ? 9 : nw;
			eh = (nh < 9) ? 9 : nh;
			shrink = ew <= sb.eff_width() && eh <= sb.eff_height();
			// A frame left open may only carry on without frame_start when the sizes shrink.
			fs_first = open_frame ? !shrink : bit'($urandom_range(0, 1));
			set_sizes(nw, nh);
			pat = pattern_e'($urandom_range(0, 4));
			flat_level = 8'($urandom_range(0, 255));
			run_frames($urandom_range(1, 3), pat, fs_first, $urandom_range(0, 9) < 3);
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		$display("Ran %0d size settings; %0d edge signs checked, %0d mismatches.",
			phases, sb.checked, sb.errors);
		$display("Frames covered flat, binary, ramp, disc and noise content with wraps and restarts.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("log_9x9_convolution_sign verification clean");
		end else begin
			$display("log_9x9_convolution_sign verification failed");
		end
		$finish;
	end

endmodule
